// ----- rtl/romberg_integrator_defines.svh -----
// Assertion macros for the Romberg integrator RTL.
// Expect clk and rst_n in the scope of every use.
`ifndef ROMBERG_INTEGRATOR_DEFINES_SVH
`define ROMBERG_INTEGRATOR_DEFINES_SVH

// Check a property on every clock edge outside reset
`define ROMB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define ROMB_ASSERT_NEXT(lbl, ante, cons, msg) \
  `ROMB_ASSERT(lbl, ((ante) |=> (cons)), msg)

`endif

// ----- rtl/romb_pkg.sv -----
// Shared types, constants and fixed-point helpers of the Romberg integrator.
// No dependencies.
package romb_pkg;

  localparam int DATA_W          = 32;
  localparam int TOL_W           = 16;
  localparam int ROWS_W          = 4;
  localparam int TBL_W           = 48;
  localparam int SPAN_W          = 33;
  localparam int PSUM_W          = 48;
  localparam int PROD_W          = SPAN_W + PSUM_W;
  localparam int CHUNK_W         = 16;
  localparam int DIV_W           = 64;
  localparam int QB_W            = 6;
  localparam int F_QBITS         = 27;
  localparam int X_QBITS         = 48;
  localparam int DEF_MAX_ROWS    = 10;
  localparam int TOL_RESET       = 7;
  localparam int ROW_LIMIT_RESET = 10;
  localparam int IN_TDATA_W      = 64;
  localparam int OUT_TDATA_W     = 40;

  typedef enum logic [0:0] {
    REG_TOLERANCE = 1'b0,
    REG_ROW_LIMIT = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NODE,
    S_SQ,
    S_DIVS,
    S_DIVW,
    S_MUL,
    S_ROUND,
    S_RD0,
    S_RDP,
    S_EXK,
    S_EXD,
    S_EXU,
    S_DONE
  } state_t;

  typedef struct packed {
    logic            start;
    logic [QB_W-1:0] qbits;
  } div_req_t;

  localparam logic signed [TBL_W-1:0] T_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [TBL_W-1:0] T_MIN = 48'sh8000_0000_0000;

  function automatic logic signed [TBL_W-1:0] sat48(input logic signed [63:0] v);
    logic signed [TBL_W-1:0] r;
    if (v > 64'sh0000_7FFF_FFFF_FFFF) r = T_MAX;
    else if (v < 64'shFFFF_8000_0000_0000) r = T_MIN;
    else r = v[TBL_W-1:0];
    return r;
  endfunction

  function automatic logic signed [TBL_W-1:0] sat_mag48(input logic neg,
                                                         input logic [63:0] u);
    logic [63:0] nu;
    logic signed [TBL_W-1:0] r;
    nu = -u;
    if (!neg) r = (u > 64'h0000_7FFF_FFFF_FFFF) ? T_MAX : u[TBL_W-1:0];
    else r = (u > 64'h0000_8000_0000_0000) ? T_MIN : nu[TBL_W-1:0];
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_mag32(input logic neg,
                                                          input logic [TBL_W-1:0] u);
    logic [TBL_W-1:0] nu;
    logic signed [DATA_W-1:0] r;
    nu = -u;
    if (!neg) r = (u > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : u[DATA_W-1:0];
    else r = (u > 48'h0000_8000_0000) ? 32'sh8000_0000 : nu[DATA_W-1:0];
    return r;
  endfunction

endpackage

// ----- rtl/romb_div.sv -----
// Radix-2 restoring divider shared by the integrand and the extrapolation.
// Depends on romb_pkg and romberg_integrator_defines.svh.
`include "romberg_integrator_defines.svh"
module romb_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  romb_pkg::div_req_t               req,
  input  logic [romb_pkg::DIV_W-1:0]       dividend,
  input  logic [romb_pkg::DIV_W-1:0]       divisor,
  output logic                             done,
  output logic [romb_pkg::DIV_W-1:0]       quotient
);
  import romb_pkg::*;

  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] sh_r, sh_nxt;
  logic [DIV_W-1:0] q_r, q_nxt;
  logic [DIV_W-1:0] d_r, d_nxt;
  logic [QB_W-1:0]  cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DIV_W:0]   rem2;
  logic             ge;

  assign rem2 = {rem_r, sh_r[DIV_W-1]};
  assign ge   = (rem2 >= {1'b0, d_r});

  always_comb begin
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = dividend >> req.qbits;
      sh_nxt   = dividend << (7'(DIV_W) - 7'(req.qbits));
      q_nxt    = '0;
      d_nxt    = divisor;
      cnt_nxt  = req.qbits;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? DIV_W'(rem2 - {1'b0, d_r}) : DIV_W'(rem2);
      sh_nxt  = sh_r << 1;
      q_nxt   = {q_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == QB_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

  `ROMB_ASSERT(a_start_idle, (req.start |-> !busy_r), "divider started while busy")
  `ROMB_ASSERT(a_busy_cnt, (busy_r |-> (cnt_r != '0)), "divider busy with no steps left")
  `ROMB_ASSERT_NEXT(a_start_busy, req.start, busy_r, "divider failed to start")

endmodule

// ----- rtl/romberg_integrator.sv -----
// Romberg integrator of 4/(1+x^2): top level with sequencer and row memory.
// Depends on romb_pkg, romb_div and romberg_integrator_defines.svh.
//
// Usage:
//   in_*  : one word per interval, lower bound in tdata[31:0], upper in [63:32].
//   out_* : one word per interval, integral in tdata[31:0], rows used in
//           tdata[35:32], converged flag in tuser.
//   cfg_* : register writes, index 0 tolerance, index 1 row limit; write only
//           while the block is idle. cfg_ready is always high.
// Operation: one interval at a time. Each integrand point uses the 27-step
// serial divider; round m evaluates 2^(m-1) points, row zero two, and each
// extrapolation step uses the same divider.
// The row memory read data is registered; no clearing pass is needed.
// Reset: registers return to tolerance 7 and row limit 10, no word pending.
// Stall: a finished word waits in the output register while the next
// interval is already accepted and worked on; the sequencer holds only if a
// second result is ready before the first is taken.
`include "romberg_integrator_defines.svh"
module romberg_integrator #(
  parameter int MAX_ROWS = romb_pkg::DEF_MAX_ROWS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [romb_pkg::IN_TDATA_W-1:0]    in_tdata,   // lower_bound, upper_bound
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [romb_pkg::OUT_TDATA_W-1:0]   out_tdata,  // integral, rows_used, zero pad
  output logic                               out_tuser,  // converged
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [romb_pkg::TOL_W-1:0]         cfg_data
);
  import romb_pkg::*;

  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int AW = $clog2(MAX_ROWS);
  localparam int IW = MAX_ROWS;

  state_t state_r, state_nxt;
  logic signed [DATA_W-1:0] a_r, a_nxt, b_r, b_nxt, x_r, x_nxt;
  logic signed [SPAN_W-1:0] span_r, span_nxt;
  logic [SPAN_W-1:0]        uspan_r, uspan_nxt;
  logic                     neg_r, neg_nxt;
  logic [RW-1:0]            lim_r, lim_nxt, m_r, m_nxt, k_r, k_nxt;
  logic [IW-1:0]            i_r, i_nxt;
  logic                     first_r, first_nxt;
  logic signed [63:0]       t_r, t_nxt;
  logic [63:0]              den_r, den_nxt;
  logic [PSUM_W-1:0]        psum_r, psum_nxt;
  logic [PROD_W-1:0]        prod_r, prod_nxt;
  logic [1:0]               mc_r, mc_nxt;
  logic signed [TBL_W-1:0]  cur_r, cur_nxt, hp_r, hp_nxt, prev_r, prev_nxt;
  logic signed [TBL_W-1:0]  diag_r, diag_nxt;
  logic                     vneg_r, vneg_nxt, conv_r, conv_nxt;
  logic [TOL_W-1:0]         tol_r;
  logic [ROWS_W-1:0]        rlim_r;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_int_r, out_int_nxt;
  logic                     out_conv_r, out_conv_nxt;
  logic [ROWS_W-1:0]        out_rows_r, out_rows_nxt;

  logic signed [TBL_W-1:0]  mem [MAX_ROWS];
  logic signed [TBL_W-1:0]  rdata_r;
  logic [AW-1:0]            mem_raddr, mem_waddr;
  logic                     mem_we;
  logic signed [TBL_W-1:0]  mem_wdata;

  div_req_t                 div_req;
  logic [DIV_W-1:0]         div_dividend, div_divisor, div_q;
  logic                     div_done;

  // datapath terms
  logic [63:0]              t_mag, node_rnd, dk, qs_u, rp;
  logic signed [63:0]       node_off, q_sum;
  logic [DATA_W-1:0]        ux;
  logic [63:0]              sq;
  logic [CHUNK_W-1:0]       chunk;
  logic [SPAN_W+CHUNK_W-1:0] pp;
  logic [QB_W-1:0]          rsh;
  logic [PROD_W-1:0]        rp_full;
  logic signed [TBL_W:0]    s0, v, dif;
  logic [TBL_W:0]           s0_mag, v_mag, dif_mag;
  logic [TBL_W-1:0]         diag_mag, out_mag;
  logic [IW-1:0]            n_pts;
  logic                     last_pt;
  logic signed [DATA_W-1:0] b_in, a_in;
  logic signed [SPAN_W-1:0] span_in;

  assign a_in    = in_tdata[DATA_W-1:0];
  assign b_in    = in_tdata[2*DATA_W-1:DATA_W];
  assign span_in = {b_in[DATA_W-1], b_in} - {a_in[DATA_W-1], a_in};

  assign t_mag    = t_r[63] ? -t_r : t_r;
  assign node_rnd = (t_mag + (64'd1 << (m_r - 1'b1))) >> m_r;
  assign node_off = t_r[63] ? -$signed(node_rnd) : $signed(node_rnd);

  assign ux = x_r[DATA_W-1] ? -x_r : x_r;
  assign sq = ux * ux;

  assign chunk = CHUNK_W'(psum_r >> {mc_r, 4'b0});
  assign pp    = uspan_r * chunk;

  assign rsh     = first_r ? QB_W'(17) : QB_W'(15) + QB_W'(m_r);
  assign rp_full = (prod_r + (PROD_W'(1) << (rsh - 1'b1))) >> rsh;
  assign rp      = rp_full[63:0];

  assign s0     = {rdata_r[TBL_W-1], rdata_r} + {hp_r[TBL_W-1], hp_r};
  assign s0_mag = s0[TBL_W] ? -s0 : s0;

  assign v     = {cur_r[TBL_W-1], cur_r} - {rdata_r[TBL_W-1], rdata_r};
  assign v_mag = v[TBL_W] ? -v : v;
  assign dk    = (64'd1 << {k_r, 1'b0}) - 64'd1;

  assign qs_u  = vneg_r ? -div_q : div_q;
  assign q_sum = 64'(cur_r) + $signed(qs_u);

  assign dif     = {cur_r[TBL_W-1], cur_r} - {prev_r[TBL_W-1], prev_r};
  assign dif_mag = dif[TBL_W] ? -dif : dif;

  assign diag_mag = diag_r[TBL_W-1] ? -diag_r : diag_r;
  assign out_mag  = (diag_mag + 48'd128) >> 8;

  assign n_pts   = IW'(1) << (m_r - 1'b1);
  assign last_pt = first_r ? (i_r == IW'(1)) : ((i_r + IW'(1)) == n_pts);

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    x_nxt         = x_r;
    span_nxt      = span_r;
    uspan_nxt     = uspan_r;
    neg_nxt       = neg_r;
    lim_nxt       = lim_r;
    m_nxt         = m_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    first_nxt     = first_r;
    t_nxt         = t_r;
    den_nxt       = den_r;
    psum_nxt      = psum_r;
    prod_nxt      = prod_r;
    mc_nxt        = mc_r;
    cur_nxt       = cur_r;
    hp_nxt        = hp_r;
    prev_nxt      = prev_r;
    diag_nxt      = diag_r;
    vneg_nxt      = vneg_r;
    conv_nxt      = conv_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_int_nxt   = out_int_r;
    out_conv_nxt  = out_conv_r;
    out_rows_nxt  = out_rows_r;
    in_tready     = 1'b0;
    mem_raddr     = '0;
    mem_waddr     = '0;
    mem_we        = 1'b0;
    mem_wdata     = cur_r;
    div_req.start = 1'b0;
    div_req.qbits = QB_W'(F_QBITS);
    div_dividend  = (64'd1 << 58) + (den_r >> 1);
    div_divisor   = den_r;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          a_nxt     = a_in;
          b_nxt     = b_in;
          span_nxt  = span_in;
          uspan_nxt = span_in[SPAN_W-1] ? -span_in : span_in;
          neg_nxt   = span_in[SPAN_W-1];
          if (rlim_r < ROWS_W'(2)) lim_nxt = RW'(2);
          else if (32'(rlim_r) > MAX_ROWS) lim_nxt = RW'(MAX_ROWS);
          else lim_nxt = RW'(rlim_r);
          m_nxt     = RW'(1);
          i_nxt     = '0;
          psum_nxt  = '0;
          first_nxt = 1'b1;
          t_nxt     = 64'(span_in);
          conv_nxt  = 1'b0;
          state_nxt = S_NODE;
        end
      end
      S_NODE: begin
        if (first_r) begin
          x_nxt = (i_r == '0) ? a_r : b_r;
        end else begin
          x_nxt = DATA_W'(64'(a_r) + node_off);
          t_nxt = t_r + (64'(span_r) <<< 1);
        end
        state_nxt = S_SQ;
      end
      S_SQ: begin
        den_nxt   = sq + (64'd1 << 32);
        state_nxt = S_DIVS;
      end
      S_DIVS: begin
        div_req.start = 1'b1;
        state_nxt     = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) begin
          psum_nxt = psum_r + PSUM_W'(div_q[F_QBITS-1:0]);
          i_nxt    = i_r + IW'(1);
          if (last_pt) begin
            prod_nxt  = '0;
            mc_nxt    = '0;
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_NODE;
          end
        end
      end
      S_MUL: begin
        prod_nxt = prod_r + (PROD_W'(pp) << {mc_r, 4'b0});
        mc_nxt   = mc_r + 2'd1;
        if (mc_r == 2'd2) state_nxt = S_ROUND;
      end
      S_ROUND: begin
        hp_nxt = sat_mag48(neg_r, rp);
        if (first_r) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = sat_mag48(neg_r, rp);
          diag_nxt  = sat_mag48(neg_r, rp);
          first_nxt = 1'b0;
          i_nxt     = '0;
          psum_nxt  = '0;
          t_nxt     = 64'(span_r);
          state_nxt = S_NODE;
        end else begin
          mem_raddr = '0;
          state_nxt = S_RD0;
        end
      end
      S_RD0: begin
        cur_nxt   = sat_mag48(s0[TBL_W], 64'((s0_mag + 1'b1) >> 1));
        mem_raddr = AW'(m_r - 1'b1);
        state_nxt = S_RDP;
      end
      S_RDP: begin
        prev_nxt  = rdata_r;
        k_nxt     = RW'(1);
        mem_raddr = '0;
        state_nxt = S_EXK;
      end
      S_EXK: begin
        vneg_nxt      = v[TBL_W];
        div_req.start = 1'b1;
        div_req.qbits = QB_W'(X_QBITS);
        div_dividend  = 64'(v_mag) + (dk >> 1);
        div_divisor   = dk;
        mem_we        = 1'b1;
        mem_waddr     = AW'(k_r - 1'b1);
        state_nxt     = S_EXD;
      end
      S_EXD: begin
        if (div_done) begin
          cur_nxt = sat48(q_sum);
          if (k_r == m_r) begin
            state_nxt = S_EXU;
          end else begin
            k_nxt     = k_r + 1'b1;
            mem_raddr = AW'(k_r);
            state_nxt = S_EXK;
          end
        end
      end
      S_EXU: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(m_r);
        diag_nxt  = cur_r;
        m_nxt     = m_r + 1'b1;
        if ((tol_r != '0) && (dif_mag < {25'b0, tol_r, 8'b0})) begin
          conv_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else if ((m_r + 1'b1) >= lim_r) begin
          state_nxt = S_DONE;
        end else begin
          i_nxt     = '0;
          psum_nxt  = '0;
          t_nxt     = 64'(span_r);
          state_nxt = S_NODE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_int_nxt   = sat_mag32(diag_r[TBL_W-1], out_mag);
          out_conv_nxt  = conv_r;
          out_rows_nxt  = ROWS_W'(m_r);
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    x_r        <= x_nxt;
    span_r     <= span_nxt;
    uspan_r    <= uspan_nxt;
    neg_r      <= neg_nxt;
    lim_r      <= lim_nxt;
    m_r        <= m_nxt;
    k_r        <= k_nxt;
    i_r        <= i_nxt;
    first_r    <= first_nxt;
    t_r        <= t_nxt;
    den_r      <= den_nxt;
    psum_r     <= psum_nxt;
    prod_r     <= prod_nxt;
    mc_r       <= mc_nxt;
    cur_r      <= cur_nxt;
    hp_r       <= hp_nxt;
    prev_r     <= prev_nxt;
    diag_r     <= diag_nxt;
    vneg_r     <= vneg_nxt;
    conv_r     <= conv_nxt;
    out_int_r  <= out_int_nxt;
    out_conv_r <= out_conv_nxt;
    out_rows_r <= out_rows_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      tol_r       <= TOL_W'(TOL_RESET);
      rlim_r      <= ROWS_W'(ROW_LIMIT_RESET);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_reg_t'(cfg_index))
          REG_TOLERANCE: tol_r  <= cfg_data;
          REG_ROW_LIMIT: rlim_r <= cfg_data[ROWS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  romb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_rows_r, out_int_r};
  assign out_tuser  = out_conv_r;

  `ROMB_ASSERT(a_div_wait, (div_done |-> (state_r == S_DIVW || state_r == S_EXD)), "divider result with no waiter")
  `ROMB_ASSERT(a_k_range, ((state_r == S_EXK) |-> (k_r >= RW'(1) && k_r <= m_r)), "extrapolation index out of range")
  `ROMB_ASSERT(a_round_lim, ((state_r == S_NODE && !first_r) |-> (m_r < lim_r)), "round beyond row limit")
  `ROMB_ASSERT_NEXT(a_accept_start, (in_tvalid && in_tready), (state_r == S_NODE), "accepted word not started")

endmodule
